// ----- rtl/spi_pkg.sv -----
// Shared types and constants for the servo pose interpolator.
// Used by spi_div and servo_pose_interpolator; depends on nothing.
package spi_pkg;

    localparam int MAX_SERVOS = 32;
    localparam int SLOT_W     = $clog2(MAX_SERVOS);
    localparam int CNT_W      = $clog2(MAX_SERVOS + 1);

    localparam int POS_W  = 12;
    localparam int STEP_W = 13;
    localparam int CHAN_W = 8;
    localparam int FL_W   = 10;
    localparam int PS_W   = 6;
    localparam int MT_W   = 16;
    localparam int SEV_W  = 7;

    // divider: dividend and quotient width, divisor width
    localparam int DIVD_W = 16;
    localparam int DIVS_W = 17;

    localparam logic [FL_W-1:0]  FL_RESET  = 10'd20;
    localparam logic [PS_W-1:0]  PS_RESET  = 6'd18;
    localparam logic [POS_W-1:0] POS_RESET = 12'd1500;

    localparam logic CFG_FRAME_LENGTH = 1'b0;
    localparam logic CFG_POSE_SIZE    = 1'b1;

    typedef enum logic [1:0] {
        MODE_SET_TARGET  = 2'd0,
        MODE_START_MOVE  = 2'd1,
        MODE_TICK        = 2'd2,
        MODE_SET_CHANNEL = 2'd3
    } t_mode;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FIND,
        ST_FRM_GO,
        ST_FRM_WAIT,
        ST_STEP_GO,
        ST_STEP_WAIT,
        ST_TICK
    } t_state;

endpackage

// ----- rtl/servo_pose_interpolator.sv -----
// Multi-servo linear pose engine: slot table, move start and frame tick.
// Depends on spi_pkg and the shared divider spi_div.
// Beats, n = slots in use: set channel updates one slot; set target searches up to n slots;
// start move divides on the serial divider, first the frame count, then one division per slot;
// frame tick steps one slot per cycle while the output is not stalled, and none when not moving.
// Ready is high only in idle. Reset sets slots to 1500, channels to the slot index.
module servo_pose_interpolator (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic                         i_cfg_idx,
    input  logic [spi_pkg::FL_W-1:0]     i_cfg_data,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic [1:0]                   i_mode,
    input  logic [4:0]                   i_slot,
    input  logic [spi_pkg::CHAN_W-1:0]   i_channel,
    input  logic [spi_pkg::POS_W-1:0]    i_position,
    input  logic [spi_pkg::MT_W-1:0]     i_move_time,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic [spi_pkg::CHAN_W-1:0]   o_out_channel,
    output logic [spi_pkg::POS_W-1:0]    o_out_position,
    output logic [spi_pkg::SEV_W-1:0]    o_low_seven,
    output logic [spi_pkg::SEV_W-1:0]    o_high_seven,
    output logic                         o_last
);
    import spi_pkg::*;

    t_state r_state, n_state;

    logic [FL_W-1:0]   r_frame_length;
    logic [PS_W-1:0]   r_pose_size;
    logic              r_moving;
    logic              r_all_arr;
    logic [CNT_W-1:0]  r_idx;
    logic [CHAN_W-1:0] r_channel;
    logic [POS_W-1:0]  r_position;
    logic [MT_W-1:0]   r_move_time;
    logic [DIVS_W-1:0] r_frames;

    logic [POS_W-1:0]  r_cur  [MAX_SERVOS];
    logic [POS_W-1:0]  r_tgt  [MAX_SERVOS];
    logic [STEP_W-1:0] r_step [MAX_SERVOS];
    logic [CHAN_W-1:0] r_chan [MAX_SERVOS];

    logic              r_o_valid;
    logic [CHAN_W-1:0] r_o_chan;
    logic [POS_W-1:0]  r_o_pos;
    logic              r_o_last;

    logic              in_acc;
    logic [CNT_W-1:0]  n_slots;
    logic              idx_end;
    logic [SLOT_W-1:0] ix;
    logic [POS_W-1:0]  cur_rd;
    logic [POS_W-1:0]  tgt_rd;
    logic [STEP_W-1:0] step_rd;
    logic [CHAN_W-1:0] chan_rd;
    logic              match;
    logic [POS_W-1:0]  up_d;
    logic [POS_W-1:0]  dn_d;
    logic [POS_W-1:0]  abs_d;
    logic [POS_W-1:0]  new_pos;
    logic              arr;
    logic              out_free;
    logic              out_load;
    logic [FL_W-1:0]   fl_eff;
    logic              div_start;
    logic [DIVD_W-1:0] div_dividend;
    logic [DIVS_W-1:0] div_divisor;
    logic              div_done;
    logic [DIVD_W-1:0] div_quo;
    logic [STEP_W-1:0] step_new;

    spi_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_done     (div_done),
        .o_quotient (div_quo)
    );

    // slot datapath
    always_comb begin
        in_acc   = i_in_valid && o_in_ready;
        n_slots  = (int'(r_pose_size) > MAX_SERVOS) ? CNT_W'(MAX_SERVOS) : CNT_W'(r_pose_size);
        idx_end  = (r_idx == n_slots);
        ix       = r_idx[SLOT_W-1:0];
        cur_rd   = r_cur[ix];
        tgt_rd   = r_tgt[ix];
        step_rd  = r_step[ix];
        chan_rd  = r_chan[ix];
        match    = (chan_rd == r_channel);
        up_d     = tgt_rd - cur_rd;
        dn_d     = cur_rd - tgt_rd;
        abs_d    = (tgt_rd > cur_rd) ? up_d : dn_d;
        step_new = div_quo[STEP_W-1:0] + STEP_W'(1);
        fl_eff   = (r_frame_length == '0) ? FL_W'(1) : r_frame_length;
        out_free = !r_o_valid || i_out_ready;
        // step toward target, snap when closer than one step
        if (cur_rd == tgt_rd) begin
            new_pos = cur_rd;
            arr     = 1'b1;
        end else if ({1'b0, abs_d} < step_rd) begin
            new_pos = tgt_rd;
            arr     = 1'b1;
        end else if (tgt_rd > cur_rd) begin
            new_pos = cur_rd + step_rd[POS_W-1:0];
            arr     = 1'b0;
        end else begin
            new_pos = cur_rd - step_rd[POS_W-1:0];
            arr     = 1'b0;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    unique case (t_mode'(i_mode))
                        MODE_SET_TARGET:  n_state = ST_FIND;
                        MODE_START_MOVE:  n_state = ST_FRM_GO;
                        MODE_TICK:        n_state = r_moving ? ST_TICK : ST_IDLE;
                        MODE_SET_CHANNEL: n_state = ST_IDLE;
                        default:          n_state = ST_IDLE;
                    endcase
                end
            end
            ST_FIND: begin
                if (idx_end || match) n_state = ST_IDLE;
            end
            ST_FRM_GO:    n_state = ST_FRM_WAIT;
            ST_FRM_WAIT: begin
                if (div_done) n_state = ST_STEP_GO;
            end
            ST_STEP_GO:   n_state = idx_end ? ST_IDLE : ST_STEP_WAIT;
            ST_STEP_WAIT: begin
                if (div_done) n_state = ST_STEP_GO;
            end
            ST_TICK: begin
                if (idx_end) n_state = ST_IDLE;
            end
            default:      n_state = ST_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        o_in_ready   = (r_state == ST_IDLE);
        div_start    = (r_state == ST_FRM_GO) || ((r_state == ST_STEP_GO) && !idx_end);
        div_dividend = (r_state == ST_FRM_GO) ? r_move_time : DIVD_W'(abs_d);
        div_divisor  = (r_state == ST_FRM_GO) ? DIVS_W'(fl_eff) : r_frames;
        out_load     = (r_state == ST_TICK) && !idx_end && out_free;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= ST_IDLE;
            r_frame_length <= FL_RESET;
            r_pose_size    <= PS_RESET;
            r_moving       <= 1'b0;
            r_o_valid      <= 1'b0;
            r_idx          <= '0;
            r_all_arr      <= 1'b1;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_FRAME_LENGTH: r_frame_length <= i_cfg_data;
                    CFG_POSE_SIZE:    r_pose_size    <= i_cfg_data[PS_W-1:0];
                    default:          r_frame_length <= r_frame_length;
                endcase
            end
            if (in_acc) begin
                r_idx     <= '0;
                r_all_arr <= 1'b1;
            end
            if ((r_state == ST_FIND) && !idx_end && !match) begin
                r_idx <= r_idx + 1'b1;
            end
            if ((r_state == ST_STEP_WAIT) && div_done) begin
                r_idx <= r_idx + 1'b1;
            end
            if ((r_state == ST_STEP_GO) && idx_end) begin
                r_moving <= 1'b1;
            end
            if (out_load) begin
                r_idx     <= r_idx + 1'b1;
                r_all_arr <= r_all_arr && arr;
            end
            if ((r_state == ST_TICK) && idx_end && r_all_arr) begin
                r_moving <= 1'b0;
            end
            // hold the beat until taken, reload as soon as it leaves
            if (out_load) begin
                r_o_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    // slot table with reset values
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < MAX_SERVOS; k++) begin
                r_cur[k]  <= POS_RESET;
                r_tgt[k]  <= POS_RESET;
                r_chan[k] <= CHAN_W'(k);
            end
        end else begin
            if (in_acc && (t_mode'(i_mode) == MODE_SET_CHANNEL) && (int'(i_slot) < MAX_SERVOS)) begin
                r_chan[SLOT_W'(i_slot)] <= i_channel;
            end
            if ((r_state == ST_FIND) && !idx_end && match) begin
                r_tgt[ix] <= r_position;
            end
            if (out_load) begin
                r_cur[ix] <= new_pos;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_channel   <= i_channel;
            r_position  <= i_position;
            r_move_time <= i_move_time;
        end
        if ((r_state == ST_FRM_WAIT) && div_done) begin
            r_frames <= DIVS_W'(div_quo) + DIVS_W'(1);
        end
        if ((r_state == ST_STEP_WAIT) && div_done) begin
            r_step[ix] <= step_new;
        end
        if (out_load) begin
            r_o_chan <= chan_rd;
            r_o_pos  <= new_pos;
            r_o_last <= (r_idx + 1'b1 == n_slots);
        end
    end

    assign o_out_valid    = r_o_valid;
    assign o_out_channel  = r_o_chan;
    assign o_out_position = r_o_pos;
    assign o_low_seven    = {r_o_pos[4:0], 2'b00};
    assign o_high_seven   = r_o_pos[POS_W-1:5];
    assign o_last         = r_o_last;

    a_div_done_waited: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (r_state == ST_FRM_WAIT || r_state == ST_STEP_WAIT))
        else $error("divider finished while nobody waited for it");

    a_idx_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE) |-> (r_idx <= n_slots))
        else $error("slot index ran past the pose size");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |-> (!r_o_valid || i_out_ready))
        else $error("output beat overwritten before it was taken");

    a_stop_moving: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ST_TICK) && idx_end && r_all_arr) |=> !r_moving)
        else $error("engine still moving after all slots arrived");

endmodule

// ----- rtl/spi_div.sv -----
// Radix-2 restoring divider, one quotient bit per cycle.
// Depends on spi_pkg for operand widths.
module spi_div (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [spi_pkg::DIVD_W-1:0] i_dividend,
    input  logic [spi_pkg::DIVS_W-1:0] i_divisor,
    output logic                       o_done,
    output logic [spi_pkg::DIVD_W-1:0] o_quotient
);
    import spi_pkg::*;

    localparam int CW = $clog2(DIVD_W);

    logic              r_busy;
    logic              r_done;
    logic [CW-1:0]     r_cnt;
    logic [DIVS_W-1:0] r_rem;
    logic [DIVS_W-1:0] r_dvs;
    logic [DIVD_W-1:0] r_quo;

    logic [DIVS_W:0]   trial;
    logic [DIVS_W:0]   diff;
    logic              ge;
    logic [DIVS_W-1:0] n_rem;

    always_comb begin
        trial = {r_rem, r_quo[DIVD_W-1]};
        diff  = trial - {1'b0, r_dvs};
        ge    = (trial >= {1'b0, r_dvs});
        n_rem = ge ? diff[DIVS_W-1:0] : trial[DIVS_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CW'(DIVD_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_dvs <= i_divisor;
            r_quo <= i_dividend;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_quo <= {r_quo[DIVD_W-2:0], ge};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule
